// File: sv/fractional_baud_divisor_calc_macros.svh
// Assertion macros for the checker file of the baud divisor calculator.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef FRACTIONAL_BAUD_DIVISOR_CALC_MACROS_SVH
`define FRACTIONAL_BAUD_DIVISOR_CALC_MACROS_SVH

// Clocked property check that is switched off while reset is asserted.
`define FBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside of reset.
`define FBD_ASSERT_NEVER(lbl, cond, msg) \
	`FBD_ASSERT(lbl, !(cond), msg)

`endif

// File: sv/fbd_pkg.sv
// Package for the fractional baud divisor calculator: widths, codes, types and the ratio ROM.
// No dependencies; all other files but the macros header refer to it by scoped names.
package fbd_pkg;

	localparam int CLK_W   = 28;
	localparam int BAUD_W  = 22;
	localparam int DIV_W   = 16;
	localparam int FRAC_W  = 8;
	localparam int UNIT_W  = 28;  // 64 * baud
	localparam int QUO_W   = 22;  // widest divisor before saturation
	localparam int N_W     = 38;  // dividend register, holds 1000 * clock
	localparam int D_W     = 30;  // divisor register, holds 3 * 64 * baud
	localparam int CNT_W   = 6;
	localparam int IDX_W   = 7;
	localparam int MILLI_W = 11;
	localparam int ADDR_W  = 3;
	localparam int APB_W   = 32;

	localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET   = 28'd100000000;
	localparam logic [FRAC_W-1:0] DEFAULT_FRACTION = 8'h10;
	localparam logic [DIV_W-1:0]  DIV_MAX          = 16'hFFFF;

	// Register index decoded from paddr above the byte offset.
	localparam logic [ADDR_W-3:0] REG_CLOCK_HZ = '0;

	// Step counts of the shared unit for each operation.
	localparam logic [CNT_W-1:0] EXACT_DIV_STEPS = 6'd28;
	localparam logic [CNT_W-1:0] FRAC_DIV_STEPS  = 6'd29;
	localparam logic [CNT_W-1:0] MUL_STEPS       = 6'd22;
	localparam logic [CNT_W-1:0] RATIO_DIV_STEPS = 6'd38;

	localparam logic [IDX_W-1:0] ROM_LAST = 7'd71;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXACT_DIV,
		ST_EXACT_CHK,
		ST_FRAC_DIV,
		ST_FRAC_CHK,
		ST_MUL,
		ST_RANGE,
		ST_RATIO_DIV,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_MUL_LOAD,
		OP_MUL_STEP
	} unit_op_t;

	typedef struct packed {
		unit_op_t           op;
		logic [N_W-1:0]     dividend;    // left aligned, consumed from the MSB
		logic [D_W-1:0]     operand_b;   // divisor or multiplicand
		logic [QUO_W-1:0]   multiplier;
	} unit_cmd_t;

	typedef struct packed {
		logic [N_W-1:0] quot;
		logic [D_W-1:0] rem;          // remainder, or product after a multiply
	} unit_res_t;

	typedef struct packed {
		logic [MILLI_W-1:0] milli;
		logic [FRAC_W-1:0]  code;     // multiply value high nibble, divide-add low nibble
	} rom_entry_t;

	function automatic rom_entry_t rom_entry(input logic [IDX_W-1:0] idx);
		rom_entry_t e;
		unique case (idx)
			7'd0:  e = '{11'd1000, 8'h10};
			7'd1:  e = '{11'd1067, 8'hF1};
			7'd2:  e = '{11'd1071, 8'hE1};
			7'd3:  e = '{11'd1077, 8'hD1};
			7'd4:  e = '{11'd1083, 8'hC1};
			7'd5:  e = '{11'd1091, 8'hB1};
			7'd6:  e = '{11'd1100, 8'hA1};
			7'd7:  e = '{11'd1111, 8'h91};
			7'd8:  e = '{11'd1125, 8'h81};
			7'd9:  e = '{11'd1133, 8'hF2};
			7'd10: e = '{11'd1143, 8'h71};
			7'd11: e = '{11'd1154, 8'hD2};
			7'd12: e = '{11'd1167, 8'h61};
			7'd13: e = '{11'd1182, 8'hB2};
			7'd14: e = '{11'd1200, 8'h51};
			7'd15: e = '{11'd1214, 8'hE3};
			7'd16: e = '{11'd1222, 8'h92};
			7'd17: e = '{11'd1231, 8'hD3};
			7'd18: e = '{11'd1250, 8'h41};
			7'd19: e = '{11'd1267, 8'hF4};
			7'd20: e = '{11'd1273, 8'hB3};
			7'd21: e = '{11'd1286, 8'h72};
			7'd22: e = '{11'd1300, 8'hA3};
			7'd23: e = '{11'd1308, 8'hD4};
			7'd24: e = '{11'd1333, 8'h31};
			7'd25: e = '{11'd1357, 8'hE5};
			7'd26: e = '{11'd1364, 8'hB4};
			7'd27: e = '{11'd1375, 8'h83};
			7'd28: e = '{11'd1385, 8'hD5};
			7'd29: e = '{11'd1400, 8'h52};
			7'd30: e = '{11'd1417, 8'hC5};
			7'd31: e = '{11'd1429, 8'h73};
			7'd32: e = '{11'd1444, 8'h94};
			7'd33: e = '{11'd1455, 8'hB5};
			7'd34: e = '{11'd1462, 8'hD6};
			7'd35: e = '{11'd1467, 8'hF7};
			7'd36: e = '{11'd1500, 8'h21};
			7'd37: e = '{11'd1533, 8'hF8};
			7'd38: e = '{11'd1538, 8'hD7};
			7'd39: e = '{11'd1545, 8'hB6};
			7'd40: e = '{11'd1556, 8'h95};
			7'd41: e = '{11'd1571, 8'h74};
			7'd42: e = '{11'd1583, 8'hC7};
			7'd43: e = '{11'd1600, 8'h53};
			7'd44: e = '{11'd1615, 8'hD8};
			7'd45: e = '{11'd1625, 8'h85};
			7'd46: e = '{11'd1636, 8'hB7};
			7'd47: e = '{11'd1643, 8'hE9};
			7'd48: e = '{11'd1667, 8'h32};
			7'd49: e = '{11'd1692, 8'hD9};
			7'd50: e = '{11'd1700, 8'hA7};
			7'd51: e = '{11'd1714, 8'h75};
			7'd52: e = '{11'd1727, 8'hB8};
			7'd53: e = '{11'd1733, 8'hFB};
			7'd54: e = '{11'd1750, 8'h43};
			7'd55: e = '{11'd1769, 8'hDA};
			7'd56: e = '{11'd1778, 8'h97};
			7'd57: e = '{11'd1786, 8'hEB};
			7'd58: e = '{11'd1800, 8'h54};
			7'd59: e = '{11'd1818, 8'hB9};
			7'd60: e = '{11'd1833, 8'h65};
			7'd61: e = '{11'd1846, 8'hDB};
			7'd62: e = '{11'd1857, 8'h76};
			7'd63: e = '{11'd1867, 8'hFD};
			7'd64: e = '{11'd1875, 8'h87};
			7'd65: e = '{11'd1889, 8'h98};
			7'd66: e = '{11'd1900, 8'hA9};
			7'd67: e = '{11'd1909, 8'hBA};
			7'd68: e = '{11'd1917, 8'hCB};
			7'd69: e = '{11'd1923, 8'hDC};
			7'd70: e = '{11'd1929, 8'hED};
			7'd71: e = '{11'd1933, 8'hFE};
			default: e = '{11'd0, DEFAULT_FRACTION};
		endcase
		return e;
	endfunction

endpackage

// File: sv/fbd_req_if.sv
// Request channel of the baud divisor calculator: valid/ready plus the wanted baud rate.
// Depends on fbd_pkg for the field width.
interface fbd_req_if;
	logic                       valid;
	logic                       ready;
	logic [fbd_pkg::BAUD_W-1:0] wanted_baud;

	modport source (output valid, output wanted_baud, input ready);
	modport sink   (input valid, input wanted_baud, output ready);
endinterface

// File: sv/fbd_rsp_if.sv
// Response channel of the baud divisor calculator: valid/ready plus the divisor result.
// Depends on fbd_pkg for the field widths.
interface fbd_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [fbd_pkg::DIV_W-1:0]  baud_divisor;
	logic [fbd_pkg::FRAC_W-1:0] fraction_code;
	logic                       rate_error;

	modport source (output valid, output baud_divisor, output fraction_code,
		output rate_error, input ready);
	modport sink   (input valid, input baud_divisor, input fraction_code,
		input rate_error, output ready);
endinterface

// File: sv/fbd_shared_unit.sv
// Shared arithmetic unit: one 31-bit adder/subtractor that runs restoring division
// and shift-add multiplication one bit per cycle while its command is a step. Depends on fbd_pkg.
module fbd_shared_unit (
	input  logic               clk,
	input  fbd_pkg::unit_cmd_t cmd,
	output fbd_pkg::unit_res_t res
);

	logic [fbd_pkg::N_W-1:0] n_q;
	logic [fbd_pkg::N_W-1:0] q_q;
	logic [fbd_pkg::D_W-1:0] d_q;
	logic [fbd_pkg::D_W-1:0] r_q;

	logic [fbd_pkg::D_W:0]   trial;
	logic [fbd_pkg::D_W:0]   alu_a;
	logic [fbd_pkg::D_W:0]   alu_b;
	logic                    alu_sub;
	logic [fbd_pkg::D_W+1:0] alu_sum;
	logic                    no_borrow;

	always_comb begin
		trial = {r_q, n_q[fbd_pkg::N_W-1]};
		if (cmd.op == fbd_pkg::OP_MUL_STEP) begin
			alu_a   = {r_q, 1'b0};
			alu_b   = n_q[fbd_pkg::N_W-1] ? {1'b0, d_q} : '0;
			alu_sub = 1'b0;
		end else begin
			alu_a   = trial;
			alu_b   = {1'b0, d_q};
			alu_sub = 1'b1;
		end
		alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
			+ {{(fbd_pkg::D_W+1){1'b0}}, alu_sub};
		// In a subtraction the carry out is set when the trial remainder covers the divisor.
		no_borrow = alu_sum[fbd_pkg::D_W+1];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			fbd_pkg::OP_HOLD: begin
			end
			fbd_pkg::OP_DIV_LOAD: begin
				n_q <= cmd.dividend;
				d_q <= cmd.operand_b;
				r_q <= '0;
				q_q <= '0;
			end
			fbd_pkg::OP_DIV_STEP: begin
				r_q <= no_borrow ? alu_sum[fbd_pkg::D_W-1:0] : trial[fbd_pkg::D_W-1:0];
				q_q <= {q_q[fbd_pkg::N_W-2:0], no_borrow};
				n_q <= {n_q[fbd_pkg::N_W-2:0], 1'b0};
			end
			fbd_pkg::OP_MUL_LOAD: begin
				n_q <= {cmd.multiplier, {(fbd_pkg::N_W-fbd_pkg::QUO_W){1'b0}}};
				d_q <= cmd.operand_b;
				r_q <= '0;
			end
			fbd_pkg::OP_MUL_STEP: begin
				r_q <= alu_sum[fbd_pkg::D_W-1:0];
				n_q <= {n_q[fbd_pkg::N_W-2:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign res.quot = q_q;
	assign res.rem  = r_q;

endmodule

// File: sv/fractional_baud_divisor_calc.sv
// Fractional baud divisor calculator. Write the core clock in hertz to the register at
// byte address 0 over APB (reset value 100 MHz), then send a wanted baud rate on the
// request channel; one response follows with the 16-bit divisor-latch value (saturated
// at 65535), the fraction byte (multiply value in bits 7:4, divide-add value in bits 3:0)
// and an error flag for a zero divisor. The block handles one transaction at a time and is
// not ready while it works; the fractional path takes longest. Its pace is set by the
// shared adder/subtractor, which produces one quotient bit per cycle over three divisions
// (28, 29 and 38 steps) and one multiplier bit per cycle over 22 steps, followed by a walk
// of the ratio ROM at one entry per cycle that stops by the 67th entry, since the ratio
// stays below 1.9. A finished response waits in an output register, so the next request is
// taken while the previous one is still held; a newer result waits in the last state until
// that register is free.
// Depends on fbd_pkg, fbd_req_if, fbd_rsp_if and fbd_shared_unit.
module fractional_baud_divisor_calc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fbd_pkg::ADDR_W-1:0]  paddr,
	input  logic [fbd_pkg::APB_W-1:0]   pwdata,
	output logic [fbd_pkg::APB_W-1:0]   prdata,
	output logic                        pready,
	fbd_req_if.sink                     req,
	fbd_rsp_if.source                   rsp
);

	fbd_pkg::state_t    state_q;
	fbd_pkg::state_t    state_d;
	fbd_pkg::unit_cmd_t unit_cmd;
	fbd_pkg::unit_res_t unit_res;

	logic [fbd_pkg::CLK_W-1:0]    clock_hz_q;
	logic [fbd_pkg::BAUD_W-1:0]   baud_q;
	logic [fbd_pkg::CNT_W-1:0]    cnt_q;
	logic [fbd_pkg::IDX_W-1:0]    idx_q;
	logic [fbd_pkg::QUO_W-1:0]    res_div_q;
	logic [fbd_pkg::FRAC_W-1:0]   res_frac_q;
	logic                         res_err_q;
	logic                         rsp_valid_q;
	logic [fbd_pkg::DIV_W-1:0]    rsp_div_q;
	logic [fbd_pkg::FRAC_W-1:0]   rsp_frac_q;
	logic                         rsp_err_q;

	logic                         reg_sel;
	logic                         cfg_write;
	logic                         req_fire;
	logic                         baud_zero;
	logic [fbd_pkg::UNIT_W-1:0]   req_unit;
	logic [fbd_pkg::UNIT_W-1:0]   unit_w;
	logic [fbd_pkg::D_W-1:0]      unit3;
	logic [fbd_pkg::UNIT_W-1:0]   den;
	logic [fbd_pkg::APB_W-1:0]    clk10;
	logic [fbd_pkg::APB_W:0]      den11;
	logic [fbd_pkg::APB_W:0]      den19;
	logic [fbd_pkg::N_W-1:0]      clk1000;
	logic                         in_range;
	logic                         step_last;
	logic                         rem_zero;
	logic                         quot_zero;
	fbd_pkg::rom_entry_t          rom;
	logic                         rom_hit;
	logic                         walk_end;
	logic                         out_free;

	// Configuration port.
	assign pready    = 1'b1;
	assign reg_sel   = (paddr[fbd_pkg::ADDR_W-1:2] == fbd_pkg::REG_CLOCK_HZ);
	assign cfg_write = psel && penable && pwrite && reg_sel;
	assign prdata    = reg_sel ? {{(fbd_pkg::APB_W-fbd_pkg::CLK_W){1'b0}}, clock_hz_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= fbd_pkg::CLOCK_HZ_RESET;
		end else if (cfg_write) begin
			clock_hz_q <= pwdata[fbd_pkg::CLK_W-1:0];
		end
	end

	// Datapath helpers around the shared unit.
	assign req_fire  = req.valid && req.ready;
	assign baud_zero = (req.wanted_baud == '0);
	assign req_unit  = {req.wanted_baud, 6'b0};
	assign unit_w    = {baud_q, 6'b0};
	assign unit3     = {2'b0, unit_w} + {1'b0, unit_w, 1'b0};
	assign den       = unit_res.rem[fbd_pkg::UNIT_W-1:0];
	assign clk10     = {1'b0, clock_hz_q, 3'b0} + {3'b0, clock_hz_q, 1'b0};
	assign den11     = {2'b0, den, 3'b0} + {4'b0, den, 1'b0} + {5'b0, den};
	assign den19     = {1'b0, den, 4'b0} + {4'b0, den, 1'b0} + {5'b0, den};
	// The ratio clock / den must lie strictly between 1.1 and 1.9.
	assign in_range  = ({1'b0, clk10} > den11) && ({1'b0, clk10} < den19);
	assign clk1000   = {{(fbd_pkg::N_W-fbd_pkg::CLK_W){1'b0}}, clock_hz_q} * 38'd1000;
	assign step_last = (cnt_q == {{(fbd_pkg::CNT_W-1){1'b0}}, 1'b1});
	assign rem_zero  = (unit_res.rem == '0);
	assign quot_zero = (unit_res.quot == '0);
	// An entry lies above the ratio exactly when its thousandths exceed
	// floor(1000 * clock / den), which the last division left in the quotient.
	assign rom       = fbd_pkg::rom_entry(idx_q);
	assign rom_hit   = ({{(fbd_pkg::N_W-fbd_pkg::MILLI_W){1'b0}}, rom.milli} > unit_res.quot);
	assign walk_end  = rom_hit || (idx_q == fbd_pkg::ROM_LAST);
	assign out_free  = !rsp_valid_q || rsp.ready;

	fbd_shared_unit u_unit (
		.clk (clk),
		.cmd (unit_cmd),
		.res (unit_res)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbd_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = baud_zero ? fbd_pkg::ST_DONE : fbd_pkg::ST_EXACT_DIV;
				end
			end
			fbd_pkg::ST_EXACT_DIV: begin
				if (step_last) begin
					state_d = fbd_pkg::ST_EXACT_CHK;
				end
			end
			fbd_pkg::ST_EXACT_CHK: begin
				state_d = rem_zero ? fbd_pkg::ST_DONE : fbd_pkg::ST_FRAC_DIV;
			end
			fbd_pkg::ST_FRAC_DIV: begin
				if (step_last) begin
					state_d = fbd_pkg::ST_FRAC_CHK;
				end
			end
			fbd_pkg::ST_FRAC_CHK: begin
				state_d = quot_zero ? fbd_pkg::ST_DONE : fbd_pkg::ST_MUL;
			end
			fbd_pkg::ST_MUL: begin
				if (step_last) begin
					state_d = fbd_pkg::ST_RANGE;
				end
			end
			fbd_pkg::ST_RANGE: begin
				state_d = in_range ? fbd_pkg::ST_RATIO_DIV : fbd_pkg::ST_DONE;
			end
			fbd_pkg::ST_RATIO_DIV: begin
				if (step_last) begin
					state_d = fbd_pkg::ST_WALK;
				end
			end
			fbd_pkg::ST_WALK: begin
				if (walk_end) begin
					state_d = fbd_pkg::ST_DONE;
				end
			end
			fbd_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = fbd_pkg::ST_IDLE;
				end
			end
			default: state_d = fbd_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: request ready and the command to the shared unit.
	always_comb begin
		req.ready           = (state_q == fbd_pkg::ST_IDLE);
		unit_cmd.op         = fbd_pkg::OP_HOLD;
		unit_cmd.dividend   = '0;
		unit_cmd.operand_b  = '0;
		unit_cmd.multiplier = '0;
		unique case (state_q)
			fbd_pkg::ST_IDLE: begin
				if (req.valid && !baud_zero) begin
					unit_cmd.op        = fbd_pkg::OP_DIV_LOAD;
					unit_cmd.dividend  = {clock_hz_q, {(fbd_pkg::N_W-fbd_pkg::CLK_W){1'b0}}};
					unit_cmd.operand_b = {{(fbd_pkg::D_W-fbd_pkg::UNIT_W){1'b0}}, req_unit};
				end
			end
			fbd_pkg::ST_EXACT_CHK: begin
				if (!rem_zero) begin
					// Twice the clock, left aligned for 29 steps.
					unit_cmd.op        = fbd_pkg::OP_DIV_LOAD;
					unit_cmd.dividend  = {clock_hz_q, 1'b0,
						{(fbd_pkg::N_W-fbd_pkg::CLK_W-1){1'b0}}};
					unit_cmd.operand_b = unit3;
				end
			end
			fbd_pkg::ST_FRAC_CHK: begin
				if (!quot_zero) begin
					unit_cmd.op         = fbd_pkg::OP_MUL_LOAD;
					unit_cmd.operand_b  = {{(fbd_pkg::D_W-fbd_pkg::UNIT_W){1'b0}}, unit_w};
					unit_cmd.multiplier = unit_res.quot[fbd_pkg::QUO_W-1:0];
				end
			end
			fbd_pkg::ST_RANGE: begin
				if (in_range) begin
					unit_cmd.op        = fbd_pkg::OP_DIV_LOAD;
					unit_cmd.dividend  = clk1000;
					unit_cmd.operand_b = {{(fbd_pkg::D_W-fbd_pkg::UNIT_W){1'b0}}, den};
				end
			end
			fbd_pkg::ST_EXACT_DIV, fbd_pkg::ST_FRAC_DIV, fbd_pkg::ST_RATIO_DIV: begin
				unit_cmd.op = fbd_pkg::OP_DIV_STEP;
			end
			fbd_pkg::ST_MUL: begin
				unit_cmd.op = fbd_pkg::OP_MUL_STEP;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbd_pkg::ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				fbd_pkg::ST_IDLE:      cnt_q <= fbd_pkg::EXACT_DIV_STEPS;
				fbd_pkg::ST_EXACT_CHK: cnt_q <= fbd_pkg::FRAC_DIV_STEPS;
				fbd_pkg::ST_FRAC_CHK:  cnt_q <= fbd_pkg::MUL_STEPS;
				fbd_pkg::ST_RANGE:     cnt_q <= fbd_pkg::RATIO_DIV_STEPS;
				default:               cnt_q <= cnt_q - 1'b1;
			endcase
			if (state_q == fbd_pkg::ST_RANGE) begin
				idx_q <= '0;
			end else if (state_q == fbd_pkg::ST_WALK) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == fbd_pkg::ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result and response payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			baud_q     <= req.wanted_baud;
			res_div_q  <= '0;
			res_frac_q <= fbd_pkg::DEFAULT_FRACTION;
			res_err_q  <= 1'b1;
		end
		if (state_q == fbd_pkg::ST_EXACT_CHK || state_q == fbd_pkg::ST_FRAC_CHK) begin
			res_div_q <= unit_res.quot[fbd_pkg::QUO_W-1:0];
			res_err_q <= quot_zero;
		end
		if (state_q == fbd_pkg::ST_WALK && rom_hit) begin
			res_frac_q <= rom.code;
		end
		if (state_q == fbd_pkg::ST_DONE && out_free) begin
			rsp_div_q  <= (res_div_q[fbd_pkg::QUO_W-1:fbd_pkg::DIV_W] != '0)
				? fbd_pkg::DIV_MAX : res_div_q[fbd_pkg::DIV_W-1:0];
			rsp_frac_q <= res_frac_q;
			rsp_err_q  <= res_err_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.baud_divisor  = rsp_div_q;
	assign rsp.fraction_code = rsp_frac_q;
	assign rsp.rate_error    = rsp_err_q;

endmodule

// File: sv/fbd_checker.sv
// Port-level checker for the fractional baud divisor calculator, bound to the top level.
// Depends on fbd_pkg and the assertion macros header.
`include "fractional_baud_divisor_calc_macros.svh"

module fbd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [fbd_pkg::DIV_W-1:0]  baud_divisor,
	input logic [fbd_pkg::FRAC_W-1:0] fraction_code,
	input logic                       rate_error
);

	// The calculator works on one transaction at a time.
	`FBD_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "ready after accept")

	`FBD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(baud_divisor) && $stable(fraction_code) && $stable(rate_error), "stalled response changed")

	// An unreachable rate always reports a zero divisor and the plain fraction.
	`FBD_ASSERT_NEVER(a_err_payload, rsp_valid && rate_error && (baud_divisor != '0 || fraction_code != fbd_pkg::DEFAULT_FRACTION), "error response payload")

	`FBD_ASSERT_NEVER(a_zero_flagged, rsp_valid && !rate_error && baud_divisor == '0, "zero divisor without error")

endmodule

bind fractional_baud_divisor_calc fbd_checker u_fbd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.baud_divisor  (rsp.baud_divisor),
	.fraction_code (rsp.fraction_code),
	.rate_error    (rsp.rate_error)
);
